// ===== hw/rtl/debounced_motor_run_controller_assert.svh =====
// Assertion macros for the motor run controller RTL, included by dmrc_step.
// No dependencies; included inside module bodies after the signals exist.
`ifndef DEBOUNCED_MOTOR_RUN_CONTROLLER_ASSERT_SVH
`define DEBOUNCED_MOTOR_RUN_CONTROLLER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define DMRC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define DMRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dmrc_pkg.sv =====
// Types, codes and helpers for the debounced motor run controller.
// No dependencies; imported by every module of the block.
package dmrc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_RUN_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_RUN_TICKS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_RUN_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_THRESHOLD   = 3'd4;

    localparam logic [15:0] RST_SHORT_RUN_TICKS = 16'd15;
    localparam logic [15:0] RST_LONG_RUN_TICKS  = 16'd100;
    localparam logic [15:0] RST_PULSE_RUN_COUNT = 16'd1100;
    localparam logic [15:0] RST_DEBOUNCE_TIME   = 16'd20;
    localparam logic [11:0] RST_ADC_THRESHOLD   = 12'hD4;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_INDEX   = 2'd1;
    localparam logic [1:0] CMD_ENCODER = 2'd2;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_TIMED = 2'd1;
    localparam logic [1:0] MODE_PULSE = 2'd2;

    // x / 80 = (x >> 4) / 5, and (y * 205) >> 10 == y / 5 for y below 1024
    localparam logic [15:0] DIV5_RECIP = 16'd205;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    typedef struct packed {
        logic [15:0] short_run_ticks;
        logic [15:0] long_run_ticks;
        logic [15:0] pulse_run_count;
        logic [15:0] debounce_time;
        logic [11:0] adc_threshold;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_time;
        logic        button0_level;
        logic        button1_level;
        logic        button2_level;
        logic        direction_switch;
        logic [11:0] adc_sample;
    } in_item_t;

    typedef struct packed {
        logic [1:0] run_mode;
        logic       start_run;
        logic       stop_run;
        logic       direction;
        logic       freq_write;
        logic [5:0] freq_value;
        logic       waiting_for_index;
        logic       run_led_on;
        logic       direction_led_on;
    } result_t;

    // Frequency code for a sample already known to be at or above threshold.
    function automatic logic [5:0] freq_of(input logic [11:0] sample,
                                           input logic [11:0] thr);
        logic [11:0] diff;
        logic [15:0] prod;
        diff = sample - thr;
        prod = {8'd0, diff[11:4]} * DIV5_RECIP;
        return prod[15:10];
    endfunction

endpackage

// ===== hw/rtl/dmrc_cfg_regs.sv =====
// Configuration register file of the motor run controller.
// Depends on dmrc_pkg.
module dmrc_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dmrc_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [dmrc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output dmrc_pkg::cfg_t                      cfg
);
    import dmrc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SHORT_RUN_TICKS: cfg_next.short_run_ticks = cfg_wdata;
                CFG_LONG_RUN_TICKS:  cfg_next.long_run_ticks  = cfg_wdata;
                CFG_PULSE_RUN_COUNT: cfg_next.pulse_run_count = cfg_wdata;
                CFG_DEBOUNCE_TIME:   cfg_next.debounce_time   = cfg_wdata;
                CFG_ADC_THRESHOLD:   cfg_next.adc_threshold   = cfg_wdata[11:0];
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_run_ticks <= RST_SHORT_RUN_TICKS;
            cfg_reg.long_run_ticks  <= RST_LONG_RUN_TICKS;
            cfg_reg.pulse_run_count <= RST_PULSE_RUN_COUNT;
            cfg_reg.debounce_time   <= RST_DEBOUNCE_TIME;
            cfg_reg.adc_threshold   <= RST_ADC_THRESHOLD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/dmrc_step.sv =====
// Run state, encoder counter and button debounce, updated once per word.
// Depends on dmrc_pkg and debounced_motor_run_controller_assert.svh.
module dmrc_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  dmrc_pkg::in_item_t  item,
    input  dmrc_pkg::cfg_t      cfg,
    output dmrc_pkg::result_t   res
);
    import dmrc_pkg::*;

    logic [1:0]  mode_reg,      mode_next;
    logic [15:0] ticks_reg,     ticks_next;
    logic [31:0] enc_reg,       enc_next;
    logic [31:0] enc_start_reg, enc_start_next;
    logic [2:0]  held_reg,      held_next;
    logic [31:0] stamp_reg  [3];
    logic [31:0] stamp_next [3];
    logic        wait_reg,      wait_next;
    logic        seen_reg,      seen_next;
    logic        dir_reg,       dir_next;
    logic [5:0]  freq_reg,      freq_next;

    logic        started;
    logic        stopped;
    logic        freq_wr;
    logic [2:0]  release_hit;
    logic [2:0]  level;
    logic        sample_ok;
    logic [5:0]  freq_cand;

    assign level     = {item.button2_level, item.button1_level, item.button0_level};
    assign sample_ok = item.adc_sample >= cfg.adc_threshold;
    assign freq_cand = freq_of(item.adc_sample, cfg.adc_threshold);

    // Tick-only debounce: press stamps time; release acts if held long enough or on wrap
    always_comb begin
        logic [31:0] elapsed;
        for (int i = 0; i < 3; i++) begin
            elapsed        = item.now_time - stamp_reg[i];
            held_next[i]   = held_reg[i];
            stamp_next[i]  = stamp_reg[i];
            release_hit[i] = 1'b0;
            if (item.cmd == CMD_TICK) begin
                if (!level[i]) begin
                    if (!held_reg[i]) begin
                        held_next[i]  = 1'b1;
                        stamp_next[i] = item.now_time;
                    end
                end else if (held_reg[i] && ((item.now_time < stamp_reg[i]) ||
                                             (elapsed >= {16'd0, cfg.debounce_time}))) begin
                    held_next[i]   = 1'b0;
                    release_hit[i] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        logic [1:0]  mode_v;
        logic [31:0] enc_start_v;
        mode_v         = mode_reg;
        enc_start_v    = enc_start_reg;
        ticks_next     = ticks_reg;
        enc_next       = enc_reg;
        wait_next      = wait_reg;
        seen_next      = seen_reg;
        dir_next       = dir_reg;
        freq_next      = freq_reg;
        started        = 1'b0;
        stopped        = 1'b0;
        freq_wr        = 1'b0;
        case (item.cmd)
            CMD_INDEX: begin
                if (wait_reg) begin
                    seen_next = 1'b1;
                end
            end
            CMD_ENCODER: begin
                enc_next = enc_reg + 32'd1;
            end
            CMD_TICK: begin
                // consume an armed index hit
                if (wait_reg && seen_reg) begin
                    wait_next = 1'b0;
                    seen_next = 1'b0;
                    if (mode_v == MODE_OFF) begin
                        enc_start_v = enc_reg;
                        started     = 1'b1;
                        mode_v      = MODE_PULSE;
                    end
                end
                // advance the active run
                if (mode_v == MODE_TIMED) begin
                    if (ticks_reg != 16'd0) begin
                        ticks_next = ticks_reg - 16'd1;
                    end else begin
                        mode_v  = MODE_OFF;
                        stopped = 1'b1;
                    end
                end else if (mode_v == MODE_PULSE) begin
                    if ((enc_reg - enc_start_v) > {16'd0, cfg.pulse_run_count}) begin
                        mode_v  = MODE_OFF;
                        stopped = 1'b1;
                    end
                end
                // button releases, button 0 first
                if (release_hit[0] && mode_v == MODE_OFF) begin
                    ticks_next = cfg.short_run_ticks;
                    started    = 1'b1;
                    mode_v     = MODE_TIMED;
                end
                if (release_hit[1] && mode_v == MODE_OFF) begin
                    ticks_next = cfg.long_run_ticks;
                    started    = 1'b1;
                    mode_v     = MODE_TIMED;
                end
                if (release_hit[2]) begin
                    wait_next = 1'b1;
                end
            end
            default: ;  // undefined command: hold all state
        endcase
        if (started) begin
            dir_next = item.direction_switch;
            if (sample_ok) begin
                freq_next = freq_cand;
                freq_wr   = 1'b1;
            end
        end
        mode_next      = mode_v;
        enc_start_next = enc_start_v;
    end

    // Ticks and held flags only matter once loaded, but clear them anyway.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_OFF;
            ticks_reg     <= '0;
            enc_reg       <= '0;
            enc_start_reg <= '0;
            held_reg      <= '0;
            wait_reg      <= 1'b0;
            seen_reg      <= 1'b0;
            dir_reg       <= 1'b0;
            freq_reg      <= '0;
        end else if (fire) begin
            mode_reg      <= mode_next;
            ticks_reg     <= ticks_next;
            enc_reg       <= enc_next;
            enc_start_reg <= enc_start_next;
            held_reg      <= held_next;
            wait_reg      <= wait_next;
            seen_reg      <= seen_next;
            dir_reg       <= dir_next;
            freq_reg      <= freq_next;
        end
    end

    // Stamps are read only while the matching held flag is set.
    always_ff @(posedge aclk) begin
        if (fire && item.cmd == CMD_TICK) begin
            for (int i = 0; i < 3; i++) begin
                stamp_reg[i] <= stamp_next[i];
            end
        end
    end

    always_comb begin
        res.run_mode          = mode_next;
        res.start_run         = started;
        res.stop_run          = stopped;
        res.direction         = dir_next;
        res.freq_write        = freq_wr;
        res.freq_value        = freq_next;
        res.waiting_for_index = wait_next;
        res.run_led_on        = mode_next != MODE_OFF;
        res.direction_led_on  = item.direction_switch;
    end

    `include "debounced_motor_run_controller_assert.svh"

    `DMRC_ASSERT_NOW(a_seen_needs_wait, aclk, aresetn, 1'b1, !seen_reg || wait_reg, "index hit without wait")
    `DMRC_ASSERT_NOW(a_stop_needs_run, aclk, aresetn, fire && stopped, mode_reg != MODE_OFF, "stop while off")
    `DMRC_ASSERT_NOW(a_start_leaves_run, aclk, aresetn, fire && started, mode_next != MODE_OFF, "start left block off")
    `DMRC_ASSERT_NEXT(a_enc_count, aclk, aresetn, fire && item.cmd == CMD_ENCODER, enc_reg == $past(enc_reg) + 32'd1, "encoder count slip")

endmodule

// ===== hw/rtl/debounced_motor_run_controller.sv =====
// Top level of the debounced motor run controller: stream ports, input and result registers.
// Depends on dmrc_pkg, dmrc_cfg_regs and dmrc_step.
//
//  channel  | direction | words per item | payload
//  ---------+-----------+----------------+---------------------------------------
//  s_       | in        | 1              | tuser: event kind; tdata: time, pins, ADC
//  m_       | out       | 1              | tdata: run state and latched settings
//  cfg_     | in        | n/a            | register index and data, one write per cycle
//
// One word per cycle sustained while m_tready stays high; a word is held in the input register,
// and its result is loaded into the result register once that register is free or being drained.
// Run state updates as the result register is loaded, fed straight back for the following word.
// A stalled result register holds while the input register may still take one word.
// Reset is synchronous, active low; it clears run state, counters and valid flags.
module debounced_motor_run_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] now_time, [32] button0_level, [33] button1_level, [34] button2_level,
    // [35] direction_switch, [47:36] adc_sample
    input  logic [dmrc_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] cmd
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] run_mode, [2] start_run, [3] stop_run, [4] direction, [5] freq_write,
    // [11:6] freq_value, [12] waiting_for_index, [13] run_led_on,
    // [14] direction_led_on, [15] zero
    output logic [dmrc_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [dmrc_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [dmrc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import dmrc_pkg::*;

    cfg_t      cfg;
    in_item_t  item_reg;
    in_item_t  item_next;
    result_t   res;
    logic      in_valid_reg,  in_valid_next;
    logic      out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic      s_fire;
    logic      advance;

    dmrc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dmrc_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // advance the held word when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        item_next.cmd              = s_tuser;
        item_next.now_time         = s_tdata[31:0];
        item_next.button0_level    = s_tdata[32];
        item_next.button1_level    = s_tdata[33];
        item_next.button2_level    = s_tdata[34];
        item_next.direction_switch = s_tdata[35];
        item_next.adc_sample       = s_tdata[47:36];
    end

    always_comb begin
        out_data_next = {1'b0, res.direction_led_on, res.run_led_on, res.waiting_for_index,
                         res.freq_value, res.freq_write, res.direction, res.stop_run,
                         res.start_run, res.run_mode};
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= item_next;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== bench/dmrc_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the motor run controller bench: follows register writes, predicts one
// result word per accepted input word and compares each result field by field.
// Depends on dmrc_pkg for item and result layouts, codes and register reset values.
module dmrc_result_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [dmrc_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [1:0]                        s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [dmrc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [dmrc_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [dmrc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output int unsigned                       mismatches,
    output int unsigned                       pending
);
    import dmrc_pkg::*;

    cfg_t        regs;
    logic [1:0]  run_state;
    logic [15:0] ticks_left;
    logic [31:0] encoder_count;
    logic [31:0] encoder_base;
    logic [2:0]  held;
    logic [31:0] press_time [3];
    logic        index_armed;
    logic        index_hit;
    logic        dir_latched;
    logic [5:0]  freq_latched;
    result_t     owed_results [$];
    int unsigned results_seen;

    task automatic log_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        mismatches++;
        $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
                 $time, results_seen, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            log_mismatch(what, got, want);
    endtask

    // Latch direction, and frequency when the sample reaches the threshold.
    function automatic logic latch_run_settings(input logic dir, input logic [11:0] adc);
        logic [11:0] span;
        dir_latched = dir;
        if (adc >= regs.adc_threshold) begin
            span = (adc - regs.adc_threshold) / 12'd80;
            freq_latched = span[5:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Active-low button; acts on release once held long enough, or when time has wrapped.
    function automatic logic button_released(input int b, input logic level,
                                             input logic [31:0] now);
        if (!level) begin
            if (!held[b]) begin
                held[b] = 1'b1;
                press_time[b] = now;
            end
            return 1'b0;
        end
        if (held[b] && (now < press_time[b] ||
                        now - press_time[b] >= {16'd0, regs.debounce_time})) begin
            held[b] = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t advance_controller(input in_item_t w);
        result_t r;
        logic    started;
        logic    stopped;
        logic    freq_wr;
        logic    b0_go;
        logic    b1_go;
        logic    b2_go;
        started = 1'b0;
        stopped = 1'b0;
        freq_wr = 1'b0;
        if (w.cmd == CMD_INDEX) begin
            if (index_armed)
                index_hit = 1'b1;
        end else if (w.cmd == CMD_ENCODER) begin
            encoder_count = encoder_count + 32'd1;
        end else if (w.cmd == CMD_TICK) begin
            // an armed index hit is consumed even when a run blocks the start
            if (index_armed && index_hit) begin
                index_armed = 1'b0;
                index_hit = 1'b0;
                if (run_state == MODE_OFF) begin
                    encoder_base = encoder_count;
                    freq_wr = latch_run_settings(w.direction_switch, w.adc_sample);
                    started = 1'b1;
                    run_state = MODE_PULSE;
                end
            end
            if (run_state == MODE_TIMED) begin
                if (ticks_left != 16'd0) begin
                    ticks_left = ticks_left - 16'd1;
                end else begin
                    run_state = MODE_OFF;
                    stopped = 1'b1;
                end
            end else if (run_state == MODE_PULSE) begin
                if (encoder_count - encoder_base > {16'd0, regs.pulse_run_count}) begin
                    run_state = MODE_OFF;
                    stopped = 1'b1;
                end
            end
            b0_go = button_released(0, w.button0_level, w.now_time);
            b1_go = button_released(1, w.button1_level, w.now_time);
            b2_go = button_released(2, w.button2_level, w.now_time);
            if (b0_go && run_state == MODE_OFF) begin
                ticks_left = regs.short_run_ticks;
                freq_wr = freq_wr | latch_run_settings(w.direction_switch, w.adc_sample);
                started = 1'b1;
                run_state = MODE_TIMED;
            end
            if (b1_go && run_state == MODE_OFF) begin
                ticks_left = regs.long_run_ticks;
                freq_wr = freq_wr | latch_run_settings(w.direction_switch, w.adc_sample);
                started = 1'b1;
                run_state = MODE_TIMED;
            end
            if (b2_go)
                index_armed = 1'b1;
        end
        r.run_mode = run_state;
        r.start_run = started;
        r.stop_run = stopped;
        r.direction = dir_latched;
        r.freq_write = freq_wr;
        r.freq_value = freq_latched;
        r.waiting_for_index = index_armed;
        r.run_led_on = (run_state != MODE_OFF);
        r.direction_led_on = w.direction_switch;
        return r;
    endfunction

    task automatic check_word(input logic [M_TDATA_W-1:0] d);
        result_t e;
        if (owed_results.size() == 0) begin
            log_mismatch("word with no result owed", 32'(d), '0);
        end else begin
            e = owed_results.pop_front();
            check_field("run_mode", 32'(d[1:0]), 32'(e.run_mode));
            check_field("start_run", 32'(d[2]), 32'(e.start_run));
            check_field("stop_run", 32'(d[3]), 32'(e.stop_run));
            check_field("direction", 32'(d[4]), 32'(e.direction));
            check_field("freq_write", 32'(d[5]), 32'(e.freq_write));
            check_field("freq_value", 32'(d[11:6]), 32'(e.freq_value));
            check_field("waiting_for_index", 32'(d[12]), 32'(e.waiting_for_index));
            check_field("run_led_on", 32'(d[13]), 32'(e.run_led_on));
            check_field("direction_led_on", 32'(d[14]), 32'(e.direction_led_on));
            check_field("padding", 32'(d[15]), '0);
        end
        results_seen++;
    endtask

    always @(posedge aclk) begin
        in_item_t w;
        if (!aresetn) begin
            regs.short_run_ticks = RST_SHORT_RUN_TICKS;
            regs.long_run_ticks  = RST_LONG_RUN_TICKS;
            regs.pulse_run_count = RST_PULSE_RUN_COUNT;
            regs.debounce_time   = RST_DEBOUNCE_TIME;
            regs.adc_threshold   = RST_ADC_THRESHOLD;
            run_state = MODE_OFF;
            ticks_left = '0;
            encoder_count = '0;
            encoder_base = '0;
            held = '0;
            for (int b = 0; b < 3; b++)
                press_time[b] = '0;
            index_armed = 1'b0;
            index_hit = 1'b0;
            dir_latched = 1'b0;
            freq_latched = '0;
            owed_results.delete();
            results_seen = 0;
        end else begin
            // a result never leaves in the cycle its word arrives, so drain first
            if (m_tvalid && m_tready)
                check_word(m_tdata);
            if (s_tvalid && s_tready) begin
                w.cmd = s_tuser;
                w.now_time = s_tdata[31:0];
                w.button0_level = s_tdata[32];
                w.button1_level = s_tdata[33];
                w.button2_level = s_tdata[34];
                w.direction_switch = s_tdata[35];
                w.adc_sample = s_tdata[47:36];
                owed_results.push_back(advance_controller(w));
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_SHORT_RUN_TICKS: regs.short_run_ticks = cfg_wdata;
                    CFG_LONG_RUN_TICKS:  regs.long_run_ticks  = cfg_wdata;
                    CFG_PULSE_RUN_COUNT: regs.pulse_run_count = cfg_wdata;
                    CFG_DEBOUNCE_TIME:   regs.debounce_time   = cfg_wdata;
                    CFG_ADC_THRESHOLD:   regs.adc_threshold   = cfg_wdata[11:0];
                    default: ;
                endcase
            end
        end
        pending <= owed_results.size();
    end

endmodule

// ===== bench/debounced_motor_run_controller_tb.sv =====
`timescale 1ns / 100ps
// Bench top for the debounced motor run controller: clock, reset, stimulus and verdict.
// Depends on dmrc_pkg, the controller RTL and dmrc_result_checker.
module debounced_motor_run_controller_tb;
    import dmrc_pkg::*;

    localparam logic [1:0]  CMD_UNDEFINED = 2'd3;
    localparam int unsigned STALL_LIMIT   = 1000;
    localparam int unsigned HOLD_START    = 900;
    localparam int unsigned HOLD_LEN      = 64;
    localparam int unsigned STEADY_START  = 1300;
    localparam int unsigned STEADY_LEN    = 400;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int unsigned           mismatches;
    int unsigned           pending;

    bit          sender_steady = 1'b0;
    logic [31:0] wall_time = '0;
    logic [2:0]  pin_levels = 3'b111;
    logic [11:0] adc_thr_now = RST_ADC_THRESHOLD;

    debounced_motor_run_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    dmrc_result_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Result side: random back-pressure, one long hold-off and a stretch with none.
    initial begin : result_sink
        int unsigned cyc;
        cyc = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
                m_tready <= 1'b0;
            else if (cyc >= STEADY_START && cyc < STEADY_START + STEADY_LEN)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 25);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one word and hold it until taken; valid stays high into the next word unless a random gap is put in.
    task automatic send_word(input logic [1:0] kind, input logic [31:0] now,
                             input logic [2:0] buttons, input logic dir,
                             input logic [11:0] adc);
        if (!sender_steady && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {adc, dir, buttons, now};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= d;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [15:0] short_t, input logic [15:0] long_t,
                                  input logic [15:0] pulse_n, input logic [15:0] debounce_t,
                                  input logic [11:0] thr);
        logic [CFG_IDX_W-1:0] stray;
        wait_drained();
        // an index past the last register must leave everything alone
        stray = CFG_ADC_THRESHOLD + CFG_IDX_W'($urandom_range(1, 3));
        write_reg(stray, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(CFG_SHORT_RUN_TICKS, short_t);
        write_reg(CFG_LONG_RUN_TICKS, long_t);
        write_reg(CFG_PULSE_RUN_COUNT, pulse_n);
        write_reg(CFG_DEBOUNCE_TIME, debounce_t);
        write_reg(CFG_ADC_THRESHOLD, {4'd0, thr});
        cfg_wr_en <= 1'b0;
        adc_thr_now = thr;
    endtask

    // Ticks carry a coherent time and button levels that are held and released;
    // the other event kinds carry noise in the fields they do not use.
    task automatic run_random_phase(input int unsigned n_items);
        int unsigned done;
        int unsigned pick;
        logic [1:0]  kind;
        logic [11:0] adc;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                kind = CMD_TICK;
            else if (pick < 80)
                kind = CMD_ENCODER;
            else if (pick < 95)
                kind = CMD_INDEX;
            else
                kind = CMD_UNDEFINED;
            pick = $urandom_range(0, 99);
            if (pick < 15)
                adc = adc_thr_now;
            else if (pick < 25)
                adc = adc_thr_now - 12'd1;
            else
                adc = 12'($urandom_range(0, 4095));
            if (kind == CMD_TICK) begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    wall_time = $urandom();
                else if (pick < 5)
                    wall_time = 32'hFFFF_FFFF - $urandom_range(0, 12);
                else
                    wall_time = wall_time + $urandom_range(1, 6);
                for (int b = 0; b < 3; b++)
                    if ($urandom_range(0, 99) < 20)
                        pin_levels[b] = ~pin_levels[b];
                send_word(kind, wall_time, pin_levels, 1'($urandom_range(0, 1)), adc);
            end else begin
                send_word(kind, $urandom(), 3'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)), adc);
            end
            if (kind != CMD_UNDEFINED)
                done++;
        end
    endtask

    initial begin : stimulus
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening at reset values: short run 15 ticks, debounce 20, threshold 212.
        send_word(CMD_UNDEFINED, 32'hFFFF_FFFF, 3'b111, 1'b1, 12'hFFF);
        send_word(CMD_TICK, 32'd0, 3'b111, 1'b0, 12'd0);
        send_word(CMD_INDEX, 32'd0, 3'b000, 1'b0, 12'd0);
        send_word(CMD_ENCODER, 32'hFFFF_FFFF, 3'b111, 1'b1, 12'hFFF);
        send_word(CMD_TICK, 32'd1000, 3'b000, 1'b1, 12'hFFF);
        // released one unit too early: nothing acts
        send_word(CMD_TICK, 32'd1019, 3'b111, 1'b1, 12'hFFF);
        // all three act: button 0 starts, button 1 is refused, button 2 arms
        send_word(CMD_TICK, 32'd1020, 3'b111, 1'b1, 12'hFFF);
        send_word(CMD_INDEX, 32'd0, 3'b111, 1'b0, 12'd0);
        // index hit consumed while the timed run blocks the pulse start
        send_word(CMD_TICK, 32'd1021, 3'b111, 1'b0, 12'd100);
        send_word(CMD_TICK, 32'hFFFF_FFF0, 3'b110, 1'b0, 12'd0);
        for (int i = 1; i <= 13; i++)
            send_word(CMD_TICK, 32'hFFFF_FFF0 + 32'(i), 3'b110, i[0],
                      12'($urandom_range(0, 4095)));
        // run ends and, with time wrapped below the stamp, button 0 restarts it
        send_word(CMD_TICK, 32'd3, 3'b111, 1'b1, RST_ADC_THRESHOLD - 12'd1);
        send_word(CMD_TICK, 32'd4, 3'b111, 1'b0, RST_ADC_THRESHOLD);

        run_random_phase(200);

        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 12'd0);
        run_random_phase(200);

        for (int p = 0; p < 4; p++) begin
            apply_settings(16'($urandom_range(0, 20)), 16'($urandom_range(0, 60)),
                           16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                           12'($urandom_range(0, 4095)));
            sender_steady = (p == 2);
            run_random_phase(180);
        end
        sender_steady = 1'b0;

        // widest settings last: a timed run started here does not end within the phase
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF);
        run_random_phase(150);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
